/* rtl/core/ndm_pkg.sv */
// ----------------------------------------------------------------------------
// ndm_pkg: shared types and constants
// Payload structs, status codes and the reset threshold for the matcher.
// ----------------------------------------------------------------------------
package ndm_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int DIM_DEF         = 128;
    localparam int VALUE_WIDTH     = 16;
    localparam int MAX_COUNT_DEF   = 255;
    localparam int DIST_WIDTH      = 40;
    localparam logic [DIST_WIDTH-1:0] THRESH_RESET = 40'd6039798;

    localparam logic [1:0] ST_MATCH   = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_ENROLL  = 2'd2;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_ENROLL = 1'b1;

    typedef struct packed {
        logic                          op;
        logic [3:0]                    person_id;
        logic [6:0]                    elem_index;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            status;
        logic [3:0]            match_id;
        logic [DIST_WIDTH-1:0] best_distance_sq;
        logic [7:0]            sample_count;
    } t_out_item;

endpackage

/* rtl/core/ndm_ram.sv */
// ----------------------------------------------------------------------------
// ndm_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ndm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* rtl/core/nearest_descriptor_matcher.sv */
// ----------------------------------------------------------------------------
// nearest_descriptor_matcher: nearest-entry identity matcher
// Squared Euclidean distance against enrolled vectors, running-mean enroll.
// ----------------------------------------------------------------------------
//  Channel | Direction | Signals
//  input   | in        | i_in_valid, o_in_stall, i_in_data (t_in_item)
//  output  | out       | o_out_valid, i_out_stall, o_out_data (t_out_item)
//  config  | in        | i_cfg_we, i_cfg_wdata (threshold_sq)
//
// A query element takes one RAM read, one subtract-square and one accumulate
// per entry, all through one shared unit and the single RAM port. A last
// query element adds a minimum search over all entries and a state to post
// the result. An enroll element takes a read, a restoring division (skipped
// for an empty entry) and a write. Reset is synchronous and active low; it
// clears valid bits, counts and accumulators, the vector RAM is not cleared.
// While a result waits under stall the block keeps taking elements; only
// the next result stalls the input until the waiting one is taken.
module nearest_descriptor_matcher
    import ndm_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int DIM         = DIM_DEF,
    parameter int MAX_COUNT   = MAX_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [DIST_WIDTH-1:0] i_cfg_wdata
);
    localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int AW = $clog2(NUM_ENTRIES * DIM);
    localparam int CW = 8;
    localparam int PW = VALUE_WIDTH + CW + 1;   // product plus x, signed
    localparam int DIVW = PW;                   // quotient bits

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_QRD   = 4'd1;
    localparam logic [3:0] S_QWAIT = 4'd2;
    localparam logic [3:0] S_QSQ   = 4'd3;
    localparam logic [3:0] S_QACC  = 4'd4;
    localparam logic [3:0] S_MIN   = 4'd5;
    localparam logic [3:0] S_ERD   = 4'd6;
    localparam logic [3:0] S_EWAIT = 4'd7;
    localparam logic [3:0] S_EMUL  = 4'd8;
    localparam logic [3:0] S_EDIV  = 4'd9;
    localparam logic [3:0] S_EWR   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]            r_state;
    t_in_item              r_item;
    logic [EW-1:0]         r_ent;
    logic [DIVW-1:0]       r_div;    // magnitude quotient/dividend shift reg
    logic [CW:0]           r_rem;
    logic [$clog2(DIVW+1)-1:0] r_cnt;
    logic                  r_neg;
    logic [DIST_WIDTH-1:0] r_sq;
    logic [DIST_WIDTH-1:0] r_thresh;
    logic [DIST_WIDTH-1:0] r_acc   [NUM_ENTRIES];
    logic                  r_valid [NUM_ENTRIES];
    logic [CW-1:0]         r_count [NUM_ENTRIES];
    logic                  r_found;
    logic [DIST_WIDTH-1:0] r_best;
    logic [EW-1:0]         r_best_id;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    logic                   idx_ok;
    logic                   pid_ok;
    logic [EW-1:0]          cur_pid;
    logic                   fresh;
    logic signed [VALUE_WIDTH:0] diff;
    logic [VALUE_WIDTH:0]   adiff;
    logic [2*VALUE_WIDTH+1:0] sq_prod;
    logic [DIST_WIDTH:0]    acc_sum;
    logic [CW:0]            divisor;
    logic [CW+1:0]          rem_try;
    logic signed [PW-1:0]   prod;
    logic [CW-1:0]          new_count;

    assign idx_ok  = ({25'd0, r_item.elem_index} < DIM);
    assign pid_ok  = ({28'd0, i_in_data.person_id} < NUM_ENTRIES);
    assign cur_pid = EW'(r_item.person_id);
    assign fresh   = !r_valid[cur_pid] || (r_count[cur_pid] == '0);
    assign divisor = {1'b0, r_count[cur_pid]} + 1'b1;

    // Shared subtract unit, then abs for the square.
    assign diff  = $signed({r_item.value[VALUE_WIDTH-1], r_item.value})
                 - $signed({ram_rdata[VALUE_WIDTH-1], ram_rdata});
    assign adiff = diff[VALUE_WIDTH] ? (VALUE_WIDTH+1)'(0) - diff : diff;
    assign sq_prod = adiff * adiff;
    assign acc_sum = {1'b0, r_acc[r_ent]} + {1'b0, r_sq};
    assign prod  = $signed(ram_rdata) * $signed({1'b0, r_count[cur_pid]})
                 + PW'($signed(r_item.value));
    assign rem_try = {r_rem, r_div[DIVW-1]} - {1'b0, divisor};

    always_comb begin
        if (fresh) begin
            new_count = CW'(1);
        end else if (r_count[cur_pid] < CW'(MAX_COUNT)) begin
            new_count = r_count[cur_pid] + 1'b1;
        end else begin
            new_count = r_count[cur_pid];
        end
    end

    always_comb begin
        ram_we    = (r_state == S_EWR) && idx_ok;
        ram_addr  = AW'(r_ent) * AW'(DIM) + AW'(r_item.elem_index);
        if (r_state == S_ERD || r_state == S_EWAIT || r_state == S_EMUL
            || r_state == S_EDIV || r_state == S_EWR) begin
            ram_addr = AW'(cur_pid) * AW'(DIM) + AW'(r_item.elem_index);
        end
        if (fresh) begin
            ram_wdata = r_item.value;
        end else begin
            ram_wdata = r_neg ? VALUE_WIDTH'(~r_div + 1'b1) : VALUE_WIDTH'(r_div);
        end
    end

    ndm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(NUM_ENTRIES * DIM)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_thresh    <= THRESH_RESET;
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                r_acc[e]   <= '0;
                r_valid[e] <= 1'b0;
                r_count[e] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            // The result state reloads the output itself.
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in_data;
                        r_ent  <= '0;
                        if (i_in_data.op == OP_ENROLL) begin
                            r_state <= pid_ok ? S_ERD : S_IDLE;
                        end else begin
                            r_state <= S_QRD;
                        end
                    end
                end
                S_QRD: begin
                    if (!idx_ok) begin
                        r_state <= r_item.last ? S_MIN : S_IDLE;
                        r_found <= 1'b0;
                        r_best  <= '1;
                        r_best_id <= '0;
                    end else begin
                        r_state <= S_QWAIT;
                    end
                end
                S_QWAIT: r_state <= S_QSQ;
                S_QSQ: begin
                    r_sq <= ({4'd0, adiff} >= 21'(1 << 20)) ? '1
                          : DIST_WIDTH'(sq_prod);
                    r_state <= S_QACC;
                end
                S_QACC: begin
                    if (r_valid[r_ent]) begin
                        r_acc[r_ent] <= acc_sum[DIST_WIDTH] ? '1 : acc_sum[DIST_WIDTH-1:0];
                    end
                    if (r_ent == EW'(NUM_ENTRIES - 1)) begin
                        r_ent     <= '0;
                        r_found   <= 1'b0;
                        r_best    <= '1;
                        r_best_id <= '0;
                        r_state   <= r_item.last ? S_MIN : S_IDLE;
                    end else begin
                        r_ent   <= r_ent + 1'b1;
                        r_state <= S_QWAIT;
                    end
                end
                S_MIN: begin
                    if (r_valid[r_ent] && (!r_found || r_acc[r_ent] < r_best)) begin
                        r_found   <= 1'b1;
                        r_best    <= r_acc[r_ent];
                        r_best_id <= r_ent;
                    end
                    r_acc[r_ent] <= '0;
                    if (r_ent == EW'(NUM_ENTRIES - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ent <= r_ent + 1'b1;
                    end
                end
                S_ERD:   r_state <= S_EWAIT;
                S_EWAIT: r_state <= S_EMUL;
                S_EMUL: begin
                    r_neg   <= prod[PW-1];
                    r_div   <= prod[PW-1] ? DIVW'(-prod) : DIVW'(prod);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= fresh ? S_EWR : S_EDIV;
                end
                S_EDIV: begin
                    if (!rem_try[CW+1]) begin
                        r_rem <= rem_try[CW:0];
                        r_div <= {r_div[DIVW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[CW-1:0], r_div[DIVW-1]};
                        r_div <= {r_div[DIVW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ($bits(r_cnt))'(DIVW - 1)) begin
                        r_state <= S_EWR;
                    end
                end
                S_EWR: begin
                    if (r_item.last) begin
                        r_count[cur_pid] <= new_count;
                        r_valid[cur_pid] <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    // The output register is loaded only once the previous
                    // result has been taken, so a stalled transfer holds.
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        if (r_item.op == OP_QUERY) begin
                            r_out.status <= (!r_found || r_best > r_thresh)
                                          ? ST_UNKNOWN : ST_MATCH;
                            r_out.match_id         <= 4'(r_best_id);
                            r_out.best_distance_sq <= r_best;
                            r_out.sample_count     <= '0;
                        end else begin
                            r_out.status           <= ST_ENROLL;
                            r_out.match_id         <= r_item.person_id;
                            r_out.best_distance_sq <= '0;
                            r_out.sample_count     <= r_count[cur_pid];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");
    a_out_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= ST_ENROLL))
        else $error("bad status code");
endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for nearest_descriptor_matcher
// Drives enroll and query vectors one element per transfer, predicts every
// result with a behavioral copy of the matcher's table and compares each
// output transfer field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top
    import ndm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ENT = 16;
    localparam int N_DIM = 128;
    localparam longint unsigned DIST_MAX = 64'hFF_FFFF_FFFF;
    localparam longint unsigned SQ_SAT_ABS = 64'd1048576;
    // No transfer on either channel for this many cycles means the block hung.
    localparam int WATCHDOG_LIMIT = 3000;
    // Cycles the block may still be busy after the last result it owed.
    localparam int SETTLE_CYCLES = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [DIST_WIDTH-1:0] i_cfg_wdata;

    nearest_descriptor_matcher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // Behavioral copy of the matcher state. The written map tracks which
    // stored elements hold data, so that stimulus never reads an element
    // that was never written.
    // ------------------------------------------------------------------
    int              stored_vec [N_ENT][N_DIM];
    bit              written    [N_ENT][N_DIM];
    bit              ent_valid  [N_ENT];
    int unsigned     ent_count  [N_ENT];
    longint unsigned dist_acc   [N_ENT];
    longint unsigned thresh_sq;

    t_out_item pending_results[$];

    int n_items;
    int n_results;
    int n_enroll_done;
    int n_matched;
    int n_unknown;
    int n_errors;

    // Sender and receiver behavior knobs.
    bit quiet;
    int hold_req;

    // Advances the model by one accepted element; returns 1 when the
    // element closes a vector and therefore produces a result.
    function automatic bit predict_matcher(input t_in_item it, output t_out_item res);
        longint          x;
        longint          c;
        longint          d;
        longint unsigned ad;
        longint unsigned sq;
        longint unsigned best;
        int              pid;
        int              idx;
        int              best_id;
        bit              found;
        x   = longint'(it.value);
        pid = it.person_id;
        idx = it.elem_index;
        res = '0;
        if (it.op == OP_ENROLL) begin
            if (!ent_valid[pid] || ent_count[pid] == 0) begin
                stored_vec[pid][idx] = int'(x);
            end else begin
                c = ent_count[pid];
                stored_vec[pid][idx] = int'((longint'(stored_vec[pid][idx]) * c + x) / (c + 1));
            end
            written[pid][idx] = 1'b1;
            if (!it.last) return 1'b0;
            if (!ent_valid[pid] || ent_count[pid] == 0) begin
                ent_count[pid] = 1;
            end else if (ent_count[pid] < MAX_COUNT_DEF) begin
                ent_count[pid]++;
            end
            ent_valid[pid]       = 1'b1;
            res.status           = ST_ENROLL;
            res.match_id         = pid[3:0];
            res.best_distance_sq = '0;
            res.sample_count     = ent_count[pid][7:0];
            return 1'b1;
        end
        for (int e = 0; e < N_ENT; e++) begin
            if (ent_valid[e]) begin
                d  = x - longint'(stored_vec[e][idx]);
                ad = (d < 0) ? longint'(-d) : d;
                sq = (ad >= SQ_SAT_ABS) ? DIST_MAX : ad * ad;
                dist_acc[e] = dist_acc[e] + sq;
                if (dist_acc[e] > DIST_MAX) dist_acc[e] = DIST_MAX;
            end
        end
        if (!it.last) return 1'b0;
        found   = 1'b0;
        best    = DIST_MAX;
        best_id = 0;
        for (int e = 0; e < N_ENT; e++) begin
            if (ent_valid[e] && (!found || dist_acc[e] < best)) begin
                found   = 1'b1;
                best    = dist_acc[e];
                best_id = e;
            end
            dist_acc[e] = 0;
        end
        if (!found) begin
            res.status   = ST_UNKNOWN;
            res.match_id = '0;
        end else begin
            res.status   = (best > thresh_sq) ? ST_UNKNOWN : ST_MATCH;
            res.match_id = best_id[3:0];
        end
        res.best_distance_sq = best[DIST_WIDTH-1:0];
        res.sample_count     = '0;
        return 1'b1;
    endfunction

    // Every input transfer is fed to the model at the edge that accepts it.
    always @(posedge i_clk) begin
        t_out_item res;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (predict_matcher(i_in_data, res)) begin
                pending_results.insert(pending_results.size(), res);
            end
        end
    end

    // Output checker: each result transfer is matched against the oldest
    // prediction. Also runs the watchdog on transfer activity.
    int idle_cycles;
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: result with no prediction pending: %p", $realtime, o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    n_errors++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $realtime, want.status, o_out_data.status);
                end
                if (o_out_data.match_id !== want.match_id) begin
                    n_errors++;
                    $display("%0t: match_id mismatch: expected %0d, actual %0d",
                             $realtime, want.match_id, o_out_data.match_id);
                end
                if (o_out_data.best_distance_sq !== want.best_distance_sq) begin
                    n_errors++;
                    $display("%0t: best_distance_sq mismatch: expected %0d, actual %0d",
                             $realtime, want.best_distance_sq, o_out_data.best_distance_sq);
                end
                if (o_out_data.sample_count !== want.sample_count) begin
                    n_errors++;
                    $display("%0t: sample_count mismatch: expected %0d, actual %0d",
                             $realtime, want.sample_count, o_out_data.sample_count);
                end
                case (want.status)
                    ST_MATCH:   n_matched++;
                    ST_UNKNOWN: n_unknown++;
                    default:    n_enroll_done++;
                endcase
            end
        end
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, no transfer for %0d cycles",
                         $realtime, idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stalls, occasional long holds, and one very long hold
    // on request so that the block backs up into its input.
    int hold_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (quiet) begin
                i_out_stall <= 1'b0;
            end else begin
                case ($urandom_range(99)) inside
                    [0:64]:  i_out_stall <= 1'b0;
                    [65:96]: i_out_stall <= 1'b1;
                    default: begin
                        hold_left = $urandom_range(40, 10);
                        i_out_stall <= 1'b1;
                    end
                endcase
            end
        end
    end

    // Sender gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Sends one element and returns once it has been accepted. Valid stays
    // high into the next element when no gap is drawn.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        n_items++;
    endtask

    // Waits until every predicted result has arrived and the block has had
    // time to finish any element that owes no result.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input longint unsigned val);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val[DIST_WIDTH-1:0];
        thresh_sq = val & DIST_MAX;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item mk_item(input logic op, input int pid, input int idx,
                                         input int val, input bit last);
        t_in_item it;
        it.op         = op;
        it.person_id  = pid[3:0];
        it.elem_index = idx[6:0];
        it.value      = val[15:0];
        it.last       = last;
        return it;
    endfunction

    // Picks an element index that reads only written stored elements: for a
    // query, one held by every valid entry; for an enroll into a valid entry,
    // one that entry holds. A fresh entry always starts at index zero, so
    // index zero is always legal for a query.
    function automatic int pick_index(input logic op, input int pid, input int pos);
        int legal[$];
        bit ok;
        if (op == OP_ENROLL && !ent_valid[pid]) begin
            if (pos == 0) return 0;
            return ($urandom_range(1) == 1) ? (pos % N_DIM) : $urandom_range(N_DIM - 1);
        end
        for (int i = 0; i < N_DIM; i++) begin
            ok = 1'b1;
            if (op == OP_ENROLL) begin
                ok = written[pid][i];
            end else begin
                for (int e = 0; e < N_ENT; e++) begin
                    if (ent_valid[e] && !written[e][i]) ok = 1'b0;
                end
            end
            if (ok) legal.insert(legal.size(), i);
        end
        return legal[$urandom_range(legal.size() - 1)];
    endfunction

    // Element value: extremes, uniform noise, or close to what a target
    // entry holds so that queries do hit below the threshold.
    function automatic int pick_value(input int target, input int idx);
        int r;
        r = $urandom_range(99);
        if (r < 10) return -32768;
        if (r < 20) return 32767;
        if (r < 55 || !written[target][idx]) return $urandom_range(65535) - 32768;
        return stored_vec[target][idx] + $urandom_range(600) - 300;
    endfunction

    task automatic send_vector(input logic op, input int pid, input int len);
        int idx;
        int target;
        target = $urandom_range(N_ENT - 1);
        for (int pos = 0; pos < len; pos++) begin
            idx = pick_index(op, pid, pos);
            send_item(mk_item(op, (op == OP_ENROLL) ? pid : $urandom_range(15),
                              idx, pick_value(target, idx), pos == len - 1));
        end
    endtask

    // An enroll vector and a query vector sent element by element in random
    // order; each last flag closes only its own vector.
    task automatic send_interleaved(input int pid, input int len_e, input int len_q);
        int pe;
        int pq;
        int idx;
        pe = 0;
        pq = 0;
        while (pe < len_e || pq < len_q) begin
            if (pq >= len_q || (pe < len_e && $urandom_range(1) == 1)) begin
                idx = pick_index(OP_ENROLL, pid, pe);
                send_item(mk_item(OP_ENROLL, pid, idx, pick_value(pid, idx),
                                  pe == len_e - 1));
                pe++;
            end else begin
                idx = pick_index(OP_QUERY, 0, pq);
                send_item(mk_item(OP_QUERY, $urandom_range(15), idx,
                                  pick_value(pid, idx), pq == len_q - 1));
                pq++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Queries against an empty table report unknown with an all-ones distance.
    task automatic test_empty_table();
        send_item(mk_item(OP_QUERY, 15, 127, -32768, 1'b0));
        send_item(mk_item(OP_QUERY, 0, 0, 32767, 1'b1));
        send_item(mk_item(OP_QUERY, 10, 85, 0, 1'b1));
    endtask

    // Exact hits, ties between identical entries, and the threshold at its
    // extremes, including a distance equal to the threshold.
    task automatic test_match_threshold();
        int vals[4] = '{10, -20, 4096, -4096};
        for (int p = 1; p <= 2; p++) begin
            for (int i = 0; i < 4; i++) send_item(mk_item(OP_ENROLL, p, i, vals[i], i == 3));
        end
        for (int i = 0; i < 4; i++) send_item(mk_item(OP_ENROLL, 3, i, -vals[i], i == 3));
        for (int i = 0; i < 4; i++) send_item(mk_item(OP_QUERY, 0, i, vals[i], i == 3));
        write_threshold(0);
        for (int i = 0; i < 4; i++) send_item(mk_item(OP_QUERY, 0, i, vals[i], i == 3));
        for (int i = 0; i < 4; i++) send_item(mk_item(OP_QUERY, 0, i, vals[i] + 1, i == 3));
        write_threshold(DIST_MAX);
        send_item(mk_item(OP_QUERY, 0, 0, -32768, 1'b1));
        write_threshold(THRESH_RESET);
        send_item(mk_item(OP_QUERY, 0, 1, -20 + 2457, 1'b1));
        // A distance of exactly one against a threshold of one still matches.
        write_threshold(1);
        send_item(mk_item(OP_QUERY, 0, 0, 11, 1'b1));
    endtask

    // A long query at the opposite extreme pushes an accumulator to saturation.
    task automatic test_distance_saturation();
        send_item(mk_item(OP_ENROLL, 7, 0, -32768, 1'b1));
        write_threshold(DIST_MAX - 1);
        for (int i = 0; i < 257; i++) send_item(mk_item(OP_QUERY, 0, 0, 32767, i == 256));
    endtask

    // Repeated enrollment into one entry saturates its sample count.
    task automatic test_count_saturation();
        for (int i = 0; i < 256; i++) begin
            send_item(mk_item(OP_ENROLL, 5, 0, $urandom_range(65535) - 32768, 1'b1));
        end
    endtask

    // A full-length enrollment sends one element per vector position, each at its own index or at a random one.
    task automatic test_full_vector();
        send_vector(OP_ENROLL, 9, N_DIM);
    endtask

    // The receiver holds off while the sender keeps offering single-element
    // enrollments, so the block must stall its input.
    task automatic test_backpressure();
        drain();
        hold_req = 500;
        for (int i = 0; i < 20; i++) send_item(mk_item(OP_ENROLL, 5, 0, i * 97, 1'b1));
    endtask

    // Mostly well-formed vectors with random content, some interleaving,
    // quiet stretches and threshold changes between phases.
    task automatic test_random_traffic(input int n);
        int stop_at;
        int next_cfg;
        int r;
        int len;
        stop_at  = n_items + n;
        next_cfg = n_items + 50;
        while (n_items < stop_at) begin
            if (n_items >= next_cfg) begin
                quiet = 1'b0;
                case ($urandom_range(3))
                    0:       write_threshold(0);
                    1:       write_threshold(DIST_MAX);
                    2:       write_threshold($urandom_range(32'hFFFF_FFFF));
                    default: write_threshold({$urandom_range(255), $urandom()});
                endcase
                next_cfg = n_items + 50;
            end
            if ($urandom_range(19) == 0) quiet = !quiet;
            r   = $urandom_range(99);
            len = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            if (r < 40) begin
                send_vector(OP_ENROLL, $urandom_range(N_ENT - 1), len);
            end else if (r < 85) begin
                send_vector(OP_QUERY, 0, len);
            end else begin
                send_interleaved($urandom_range(N_ENT - 1), len, $urandom_range(8, 1));
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_out_stall = 1'b0;
        quiet       = 1'b0;
        hold_req    = 0;
        idle_cycles = 0;
        n_items = 0;
        n_results = 0;
        n_enroll_done = 0;
        n_matched = 0;
        n_unknown = 0;
        n_errors = 0;
        thresh_sq = THRESH_RESET;
        for (int e = 0; e < N_ENT; e++) begin
            ent_valid[e] = 1'b0;
            ent_count[e] = 0;
            dist_acc[e]  = 0;
            for (int i = 0; i < N_DIM; i++) begin
                stored_vec[e][i] = 0;
                written[e][i]    = 1'b0;
            end
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_match_threshold();
        test_distance_saturation();
        test_count_saturation();
        test_full_vector();
        test_backpressure();
        write_threshold(THRESH_RESET);
        test_random_traffic(150);

        drain();
        $display("Sent %0d element transfers; checked %0d results", n_items, n_results);
        $display("(%0d enroll, %0d match, %0d unknown) over empty table, ties, thresholds,",
                 n_enroll_done, n_matched, n_unknown);
        $display("saturation, interleaving and backpressure.");
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
